@@ rtl/hse_pkg.sv @@
// Package: shared types, constants and functions of the HMAC-SHA256 engine
`default_nettype none
package hse_pkg;

  localparam int LenBits = 61;
  localparam int QDepth = 4;
  localparam int QPtrW = 2;

  typedef enum logic [1:0] {
    REQ_KEY    = 2'd0,
    REQ_MSG    = 2'd1,
    REQ_FINISH = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_KEY  = 2'd0,
    PH_MSG  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    req_t       req;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        status;
    logic        last;
  } result_t;

  localparam logic [31:0] IpadWord = 32'h36363636;
  localparam logic [31:0] OpadWord = 32'h5c5c5c5c;
  localparam logic [7:0]  PadByte  = 8'h80;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef4a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hse_queue.sv @@
// Short item queue between the input front end and the hash back end
`default_nettype none
module hse_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire hse_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output hse_pkg::item_t     head,
  output logic               empty
);
  hse_pkg::item_t                 mem_r [hse_pkg::QDepth];
  logic [hse_pkg::QPtrW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [hse_pkg::QPtrW:0]        cnt_r, cnt_nxt;

  function automatic logic [hse_pkg::QPtrW-1:0] QPtrOne(input logic b);
    return {{(hse_pkg::QPtrW-1){1'b0}}, b};
  endfunction

  assign full  = (cnt_r == (hse_pkg::QPtrW+1)'(hse_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + QPtrOne(push);
    rp_nxt  = rp_r + QPtrOne(pop);
    cnt_nxt = cnt_r + {{hse_pkg::QPtrW{1'b0}}, push} - {{hse_pkg::QPtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/hse_core.sv @@
// Back end: key handling, SHA-256 block engine and MAC emission
`default_nettype none
module hse_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  wire hse_pkg::item_t  item,
  output logic                 item_pop,
  output logic                 res_valid,
  output hse_pkg::result_t     res,
  input  wire logic            res_ready
);
  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_LOAD    = 11'b00000000010,
    S_ROUND   = 11'b00000000100,
    S_ADD     = 11'b00000001000,
    S_PAD     = 11'b00000010000,
    S_KEYFIN  = 11'b00000100000,
    S_IPAD    = 11'b00001000000,
    S_OPAD    = 11'b00010000000,
    S_OPADFIN = 11'b00100000000,
    S_EMIT    = 11'b01000000000,
    S_REJ     = 11'b10000000000
  } st_t;

  // what to do when a compression ends
  typedef enum logic [7:0] {
    C_NONE   = 8'b00000001,
    C_KEYOV  = 8'b00000010,
    C_PAD1   = 8'b00000100,
    C_KEYDG  = 8'b00001000,
    C_IPAD   = 8'b00010000,
    C_INNER  = 8'b00100000,
    C_OPAD   = 8'b01000000,
    C_OUTER  = 8'b10000000
  } cont_t;

  st_t                      st_r;
  cont_t                    cont_r;
  cont_t                    fin_r;
  hse_pkg::phase_t          phase_r;
  logic [6:0]               kcnt_r;
  logic                     kov_r;
  logic [hse_pkg::LenBits-1:0] bcnt_r;
  logic                     pend_r;
  hse_pkg::item_t           pitem_r;
  logic [15:0][31:0]        key_r;
  logic [15:0][31:0]        blk_r;
  hse_pkg::hash_t           h_r;
  hse_pkg::hash_t           v_r;
  logic [15:0][31:0]        w_r;
  logic [5:0]               rnd_r;
  logic [2:0]               oidx_r;

  logic [31:0] t1, t2, s0, s1, wn, e, a;
  logic [3:0]  bidx;
  logic [1:0]  bsel;
  logic [5:0]  pos;
  logic [63:0] bits;

  assign pos  = bcnt_r[5:0];
  assign bidx = pos[5:2];
  assign bsel = pos[1:0];
  assign bits = 64'({bcnt_r, 3'b000});

  always_comb begin
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & v_r[5]) ^ (~e & v_r[6])) + hse_pkg::round_const(rnd_r) + w_r[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
         ^ (w_r[14] >> 10);
    wn = s1 + w_r[9] + s0 + w_r[0];
  end

  assign item_pop  = (st_r == S_IDLE) && item_valid && !pend_r;
  assign res_valid = (st_r == S_EMIT) || (st_r == S_REJ);
  always_comb begin
    res.word   = (st_r == S_EMIT) ? h_r[oidx_r] : 32'h0;
    res.idx    = (st_r == S_EMIT) ? oidx_r : 3'd0;
    res.status = (st_r == S_REJ);
    res.last   = (st_r == S_REJ) || (oidx_r == 3'd7);
  end

  function automatic logic [31:0] put_b(input logic [31:0] w, input logic [1:0] s,
                                        input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (s)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      default: r[7:0] = b;
    endcase
    return r;
  endfunction

  // pad the running block; the length goes in only when it fits
  function automatic logic [15:0][31:0] pad_block(input logic [15:0][31:0] b,
                                                  input logic [5:0] p,
                                                  input logic [63:0] len);
    logic [15:0][31:0] r;
    r = b;
    for (int i = 0; i < 16; i++) begin
      if (4'(i) > p[5:2]) r[i] = '0;
    end
    case (p[1:0])
      2'd0: r[p[5:2]] = {hse_pkg::PadByte, 24'h0};
      2'd1: r[p[5:2]] = {b[p[5:2]][31:24], hse_pkg::PadByte, 16'h0};
      2'd2: r[p[5:2]] = {b[p[5:2]][31:16], hse_pkg::PadByte, 8'h0};
      default: r[p[5:2]] = {b[p[5:2]][31:8], hse_pkg::PadByte};
    endcase
    if (p < 6'd56) begin
      r[14] = len[63:32];
      r[15] = len[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cont_r  <= C_NONE;
      fin_r   <= C_NONE;
      phase_r <= hse_pkg::PH_KEY;
      kcnt_r  <= '0;
      kov_r   <= 1'b0;
      bcnt_r  <= '0;
      pend_r  <= 1'b0;
      key_r   <= '0;
      h_r     <= hse_pkg::InitHash;
      oidx_r  <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (item_pop || pend_r) begin
            hse_pkg::item_t it;
            logic repend;
            it = pend_r ? pitem_r : item;
            repend = 1'b0;
            if (it.req == hse_pkg::REQ_CLEAR) begin
              phase_r <= hse_pkg::PH_KEY;
              kcnt_r  <= '0;
              kov_r   <= 1'b0;
              bcnt_r  <= '0;
              key_r   <= '0;
              h_r     <= hse_pkg::InitHash;
            end else if (it.req == hse_pkg::REQ_KEY) begin
              if (phase_r != hse_pkg::PH_KEY) begin
                st_r <= S_REJ;
              end else if (kov_r) begin
                blk_r[bidx] <= put_b(blk_r[bidx], bsel, it.data);
                bcnt_r <= bcnt_r + 1'b1;
                if (pos == 6'd63) begin
                  cont_r <= C_NONE;
                  st_r   <= S_LOAD;
                end
              end else if (kcnt_r < 7'd64) begin
                key_r[kcnt_r[5:2]] <= put_b(key_r[kcnt_r[5:2]], kcnt_r[1:0], it.data);
                kcnt_r <= kcnt_r + 1'b1;
              end else begin
                // hash the full key block, then absorb this byte
                kov_r  <= 1'b1;
                h_r    <= hse_pkg::InitHash;
                blk_r  <= key_r;
                bcnt_r <= hse_pkg::LenBits'(64);
                repend = 1'b1;
                pitem_r <= it;
                cont_r <= C_KEYOV;
                st_r   <= S_LOAD;
              end
            end else if (phase_r != hse_pkg::PH_MSG) begin
              repend = 1'b1;
              pitem_r <= it;
              if (phase_r == hse_pkg::PH_KEY && kov_r) begin
                st_r <= S_PAD;
                fin_r <= C_KEYDG;
              end else begin
                st_r <= S_IPAD;
              end
            end else if (it.req == hse_pkg::REQ_MSG) begin
              blk_r[bidx] <= put_b(blk_r[bidx], bsel, it.data);
              bcnt_r <= bcnt_r + 1'b1;
              if (pos == 6'd63) begin
                cont_r <= C_NONE;
                st_r   <= S_LOAD;
              end
            end else begin
              st_r  <= S_PAD;
              fin_r <= C_INNER;
            end
            pend_r <= repend;
          end
        end
        S_PAD: begin
          // length goes in a second block if needed
          blk_r  <= pad_block(blk_r, pos, bits);
          cont_r <= (pos >= 6'd56) ? C_PAD1 : fin_r;
          st_r   <= S_LOAD;
        end
        S_LOAD: begin
          w_r   <= blk_r;
          v_r   <= h_r;
          rnd_r <= '0;
          st_r  <= S_ROUND;
        end
        S_ROUND: begin
          v_r <= {v_r[6:4], v_r[3] + t1, v_r[2:0], t1 + t2};
          w_r <= {wn, w_r[15:1]};
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) st_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          unique case (cont_r)
            C_NONE, C_KEYOV: st_r <= S_IDLE;
            C_PAD1: begin
              blk_r  <= {bits[31:0], bits[63:32], 448'h0};
              cont_r <= fin_r;
              st_r   <= S_LOAD;
            end
            C_KEYDG: st_r <= S_KEYFIN;
            C_IPAD: begin
              bcnt_r  <= hse_pkg::LenBits'(64);
              phase_r <= hse_pkg::PH_MSG;
              st_r    <= S_IDLE;
            end
            C_INNER: st_r <= S_OPAD;
            C_OPAD: st_r <= S_OPADFIN;
            C_OUTER: st_r <= S_EMIT;
            default: st_r <= S_IDLE;
          endcase
        end
        S_KEYFIN: begin
          for (int i = 0; i < 8; i++) key_r[i] <= h_r[i];
          for (int i = 8; i < 16; i++) key_r[i] <= '0;
          kcnt_r <= 7'd32;
          kov_r  <= 1'b0;
          st_r   <= S_IPAD;
        end
        S_IPAD: begin
          h_r <= hse_pkg::InitHash;
          for (int i = 0; i < 16; i++) blk_r[i] <= key_r[i] ^ hse_pkg::IpadWord;
          cont_r <= C_IPAD;
          st_r   <= S_LOAD;
        end
        S_OPAD: begin
          // park the inner digest in the block; run the opad block straight from the key
          for (int i = 0; i < 8; i++) blk_r[i] <= h_r[i];
          for (int i = 0; i < 16; i++) w_r[i] <= key_r[i] ^ hse_pkg::OpadWord;
          h_r    <= hse_pkg::InitHash;
          v_r    <= hse_pkg::InitHash;
          rnd_r  <= '0;
          cont_r <= C_OPAD;
          st_r   <= S_ROUND;
        end
        S_OPADFIN: begin
          bcnt_r <= hse_pkg::LenBits'(96);
          fin_r  <= C_OUTER;
          st_r   <= S_PAD;
          oidx_r <= '0;
          phase_r <= hse_pkg::PH_DONE;
        end
        S_EMIT: begin
          if (res_ready) begin
            oidx_r <= oidx_r + 1'b1;
            if (oidx_r == 3'd7) begin
              bcnt_r <= '0;
              st_r   <= S_IDLE;
            end
          end
        end
        S_REJ: begin
          if (res_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/hmac_sha256_engine_unit.sv @@
// Top level of the HMAC-SHA256 engine: input queue, hash back end, output port
// Bytes are taken while the back end is idle; every 64th starts a compression, during which
// the queue is not popped. Finish runs three compressions before the MAC words appear, plus
// one more per extra pad block and per pending ipad block or long-key digest.
// Output words follow one per cycle while out_tready is high.
// Synchronous active-low reset clears the key, the hash state and the queue.
`default_nettype none
module hmac_sha256_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,  // data_byte
  input  wire logic [1:0]  in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata, // digest_word, word_index, 5'b0 fill
  output logic             out_tuser, // status
  output logic             out_tlast  // last_word
);
  hse_pkg::item_t   qin, qhead;
  hse_pkg::result_t res;
  logic full, empty, pop;

  assign qin.req  = hse_pkg::req_t'(in_tuser);
  assign qin.data = in_tdata;
  assign in_tready = !full;

  hse_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_tvalid && !full), .push_item(qin), .full(full),
    .pop(pop), .head(qhead), .empty(empty)
  );

  hse_core u_core (
    .clk(clk), .rst_n(rst_n),
    .item_valid(!empty), .item(qhead), .item_pop(pop),
    .res_valid(out_tvalid), .res(res), .res_ready(out_tready)
  );

  assign out_tdata = {5'b0, res.idx, res.word};
  assign out_tuser = res.status;
  assign out_tlast = res.last;
endmodule
`default_nettype wire

@@ bench/hmac_sha256_engine_unit_tb.sv @@
// Testbench for hmac_sha256_engine_unit: directed table then random key/message runs, MAC checked
`default_nettype none
module hmac_sha256_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int ItemCount = 470;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef4a3f7, 32'hc67178f2
  };

  typedef struct packed {
    hse_pkg::req_t req;
    logic [7:0]    data;
    logic          rejected;
  } word_t;

  localparam int DirRows = 21;
  localparam word_t DirTab [DirRows] = '{
    '{hse_pkg::REQ_CLEAR,  8'h00, 1'b0},
    '{hse_pkg::REQ_FINISH, 8'h00, 1'b0},
    '{hse_pkg::REQ_KEY,    8'h00, 1'b1},
    '{hse_pkg::REQ_MSG,    8'hff, 1'b0},
    '{hse_pkg::REQ_FINISH, 8'hff, 1'b0},
    '{hse_pkg::REQ_CLEAR,  8'h00, 1'b0},
    '{hse_pkg::REQ_KEY,    8'hff, 1'b0},
    '{hse_pkg::REQ_KEY,    8'h00, 1'b0},
    '{hse_pkg::REQ_KEY,    8'ha5, 1'b0},
    '{hse_pkg::REQ_MSG,    8'h00, 1'b0},
    '{hse_pkg::REQ_KEY,    8'h5a, 1'b1},
    '{hse_pkg::REQ_MSG,    8'h80, 1'b0},
    '{hse_pkg::REQ_FINISH, 8'h00, 1'b0},
    '{hse_pkg::REQ_MSG,    8'h3c, 1'b0},
    '{hse_pkg::REQ_FINISH, 8'h00, 1'b0},
    '{hse_pkg::REQ_CLEAR,  8'h00, 1'b0},
    '{hse_pkg::REQ_KEY,    8'h11, 1'b0},
    '{hse_pkg::REQ_FINISH, 8'h00, 1'b0},
    '{hse_pkg::REQ_CLEAR,  8'hff, 1'b0},
    '{hse_pkg::REQ_MSG,    8'h01, 1'b0},
    '{hse_pkg::REQ_FINISH, 8'h00, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  hmac_sha256_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  word_t words_q[$];
  word_t sent_q[$];
  hse_pkg::result_t mac_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 0;

  logic [31:0] key_store [16];
  int unsigned key_len;
  bit key_long;
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [31:0] cblk [16];
  logic [hse_pkg::LenBits-1:0] msg_len;
  hse_pkg::phase_t phase;

  function automatic void add_result(input hse_pkg::result_t r);
    mac_q.insert(mac_q.size(), r);
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = cblk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function automatic void compress_buffer();
    for (int i = 0; i < 16; i++) cblk[i] = blk[i];
    compress_block();
  endfunction

  function automatic void put_blk(input int unsigned pos, input logic [7:0] b);
    blk[(pos >> 2) & 15][31 - 8 * (pos & 3) -: 8] = b;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    put_blk(32'(msg_len[5:0]), b);
    msg_len = msg_len + 1'b1;
    if (msg_len[5:0] == 6'd0) compress_buffer();
  endfunction

  function automatic void pad_and_close();
    int unsigned pos;
    logic [63:0] bits;
    pos = 32'(msg_len[5:0]);
    bits = 64'(msg_len) << 3;
    put_blk(pos, hse_pkg::PadByte);
    for (int p = int'(pos) + 1; p < 64; p++) put_blk(p, 8'h00);
    if (pos >= 56) begin
      compress_buffer();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress_buffer();
  endfunction

  function automatic void start_keyed(input logic [31:0] pad);
    for (int i = 0; i < 8; i++) chain[i] = hse_pkg::InitHash[i];
    for (int i = 0; i < 16; i++) cblk[i] = key_store[i] ^ pad;
    compress_block();
    msg_len = hse_pkg::LenBits'(64);
  endfunction

  function automatic void clear_engine();
    for (int i = 0; i < 16; i++) begin
      key_store[i] = '0;
      blk[i] = '0;
    end
    for (int i = 0; i < 8; i++) chain[i] = hse_pkg::InitHash[i];
    key_len = 0;
    key_long = 0;
    msg_len = '0;
    phase = hse_pkg::PH_KEY;
  endfunction

  function automatic void mac_predict(input word_t it);
    logic [31:0] inner [8];
    hse_pkg::result_t r;
    case (it.req)
      hse_pkg::REQ_CLEAR: clear_engine();
      hse_pkg::REQ_KEY: begin
        if (phase != hse_pkg::PH_KEY) begin
          r = '{word: '0, idx: '0, status: 1'b1, last: 1'b1};
          add_result(r);
        end else if (key_long) begin
          absorb_byte(it.data);
        end else if (key_len < 64) begin
          key_store[key_len >> 2][31 - 8 * (key_len & 3) -: 8] = it.data;
          key_len++;
        end else begin
          key_long = 1;
          for (int i = 0; i < 8; i++) chain[i] = hse_pkg::InitHash[i];
          for (int i = 0; i < 16; i++) cblk[i] = key_store[i];
          compress_block();
          msg_len = hse_pkg::LenBits'(64);
          absorb_byte(it.data);
        end
      end
      default: begin
        if (phase != hse_pkg::PH_MSG) begin
          if (phase == hse_pkg::PH_KEY && key_long) begin
            pad_and_close();
            for (int i = 0; i < 8; i++) begin
              key_store[i] = chain[i];
              key_store[i + 8] = '0;
            end
            key_len = 32;
            key_long = 0;
          end
          start_keyed(hse_pkg::IpadWord);
          phase = hse_pkg::PH_MSG;
        end
        if (it.req == hse_pkg::REQ_MSG) begin
          absorb_byte(it.data);
        end else begin
          pad_and_close();
          for (int i = 0; i < 8; i++) inner[i] = chain[i];
          start_keyed(hse_pkg::OpadWord);
          for (int i = 0; i < 8; i++) blk[i] = inner[i];
          msg_len = hse_pkg::LenBits'(96);
          pad_and_close();
          for (int i = 0; i < 8; i++) begin
            r = '{word: chain[i], idx: 3'(i), status: 1'b0, last: (i == 7)};
            add_result(r);
          end
          msg_len = '0;
          phase = hse_pkg::PH_DONE;
        end
      end
    endcase
  endfunction

  function automatic void add_word(input hse_pkg::req_t req, input logic [7:0] d);
    word_t w;
    w = '{req: req, data: d, rejected: 1'b0};
    words_q.insert(words_q.size(), w);
  endfunction

  function automatic void build_random();
    int n, klen, mlen;
    while (words_q.size() < ItemCount) begin
      if ($urandom_range(0, 9) < 8) begin
        add_word(hse_pkg::REQ_CLEAR, 8'($urandom));
        klen = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 40);
        for (int i = 0; i < klen; i++) add_word(hse_pkg::REQ_KEY, 8'($urandom));
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++) begin
          mlen = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 30);
          for (int i = 0; i < mlen; i++) begin
            add_word(hse_pkg::REQ_MSG, 8'($urandom));
            if ($urandom_range(0, 60) == 0) add_word(hse_pkg::REQ_KEY, 8'($urandom));
          end
          add_word(hse_pkg::REQ_FINISH, 8'($urandom));
        end
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          add_word(hse_pkg::req_t'($urandom_range(0, 3)), 8'($urandom));
        end
      end
    end
    if (words_q.size() > ItemCount) words_q = words_q[0:ItemCount-1];
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = hse_pkg::REQ_KEY;
    clear_engine();
    for (int i = 0; i < DirRows; i++) words_q.insert(words_q.size(), DirTab[i]);
    build_random();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (words_q.size() > 0) begin
      int burst, gap;
      word_t w;
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < burst && words_q.size() > 0; i++) begin
        w = words_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= w.data;
        in_tuser <= w.req;
        sent_q.insert(sent_q.size(), w);
        @(posedge clk);
        while (!in_tready) @(posedge clk);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
    while (mac_q.size() > 0 || sent_q.size() > 0) @(posedge clk);
    repeat (800) @(posedge clk);
    if (mismatches == 0) begin
      $display("hmac_sha256_engine_unit verification clean");
    end else begin
      $display("hmac_sha256_engine_unit verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    word_t w;
    hse_pkg::result_t rej;
    if (rst_n && in_tvalid && in_tready) begin
      w = sent_q.pop_front();
      mac_predict(w);
      if (w.rejected) begin
        mac_q.pop_back();
        rej = '{word: 32'h0, idx: 3'd0, status: 1'b1, last: 1'b1};
        add_result(rej);
      end
    end
  end

  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= (cycles % 5 < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    hse_pkg::result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (mac_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: data %h idx %0d status %b last %b",
                   out_tdata[31:0], out_tdata[34:32], out_tuser, out_tlast);
      end else begin
        exp_r = mac_q.pop_front();
        if (out_tdata[31:0] !== exp_r.word || out_tdata[34:32] !== exp_r.idx ||
            out_tuser !== exp_r.status || out_tlast !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                     exp_r.word, exp_r.idx, exp_r.status, exp_r.last,
                     out_tdata[31:0], out_tdata[34:32], out_tuser, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("hmac_sha256_engine_unit verification failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
